>>> hw/rtl/sss_pkg.sv
package sss_pkg;

  localparam int NeedleMax = 8;
  localparam int IndexBits = 16;

  localparam int ByteBits   = 8;
  localparam int NeedleBits = NeedleMax * ByteBits;
  localparam int LenFieldW  = 4;
  localparam int MatchIdxW  = 16;
  localparam int LenBits    = $clog2(NeedleMax + 1);
  localparam int CellIdxW   = (NeedleMax > 1) ? $clog2(NeedleMax) : 1;

  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = NeedleBits;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgNeedleBytes  = 1'b0,
    CfgNeedleLength = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                 found;
    logic [MatchIdxW-1:0] match_index;
  } result_t;

endpackage

>>> hw/rtl/sss_in_if.sv
interface sss_in_if;
  logic                                valid;
  logic                                ready;
  logic [sss_pkg::ByteBits-1:0]        data_byte;
  logic                                first_byte;
  logic                                last_byte;
  logic [sss_pkg::MatchIdxW-1:0]       start_index;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  output start_index, input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                input start_index, output ready);
endinterface

>>> hw/rtl/sss_out_if.sv
interface sss_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [sss_pkg::MatchIdxW-1:0] match_index;

  modport source (output valid, output found, output match_index, input ready);
  modport sink (input valid, input found, input match_index, output ready);
endinterface

>>> hw/rtl/substring_stream_search_core.sv
// Shift-and substring search over a byte stream. One haystack byte is taken
// per beat, every cycle that input is not held off, by a row of compare cells
// (one per needle byte) whose match bits shift one cell along on each byte. A
// beat with first_byte set opens a search at start_index; at most one result
// beat follows per search: found with the start index of the first match, or
// not found at the beat with last_byte set. The result leaves through a
// registered output stage with a one-entry skid; input is held off only when
// both stages are full. Write needle_bytes and needle_length while idle;
// lengths above the needle width are clamped.
module substring_stream_search_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sss_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [sss_pkg::CfgDataBits-1:0]       cfg_wdata_i,
  sss_in_if.sink                                in_i,
  sss_out_if.source                             out_o
);

  logic [sss_pkg::NeedleBits-1:0] needle_q;
  logic [sss_pkg::LenFieldW-1:0]  len_q;
  logic [sss_pkg::IndexBits-1:0]  pos_q, pos_d, pos_cur;
  logic                           done_q, done_d, done_cur;

  logic [sss_pkg::LenBits-1:0]    len_eff, len_m1;
  logic                           len_zero;
  logic [sss_pkg::NeedleMax-1:0]  cell_en, pm_d, pm_q, prev;

  logic                           accept, adv, hit, full;
  logic                           res_valid;
  sss_pkg::result_t               res;
  logic [sss_pkg::IndexBits-1:0]  start_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      len_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sss_pkg::CfgNeedleBytes:  needle_q <= cfg_wdata_i;
        sss_pkg::CfgNeedleLength: len_q    <= cfg_wdata_i[sss_pkg::LenFieldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(len_q) > sss_pkg::NeedleMax) begin
      len_eff = sss_pkg::LenBits'(sss_pkg::NeedleMax);
    end else begin
      len_eff = sss_pkg::LenBits'(len_q);
    end
    len_zero = (len_eff == '0);
    len_m1   = len_eff - sss_pkg::LenBits'(1);
    for (int k = 0; k < sss_pkg::NeedleMax; k++) begin
      cell_en[k] = (k < int'(len_eff));
    end
  end

  assign accept   = in_i.valid & in_i.ready;
  assign done_cur = in_i.first_byte ? 1'b0 : done_q;
  assign pos_cur  = in_i.first_byte ? sss_pkg::IndexBits'(in_i.start_index) : pos_q;
  assign adv      = accept & ~done_cur;

  // first byte restarts the vector: drop the neighbor bits, keep the seed into cell 0
  always_comb begin
    prev[0] = 1'b1;
    for (int k = 1; k < sss_pkg::NeedleMax; k++) begin
      prev[k] = pm_q[k-1] & ~in_i.first_byte;
    end
  end

  for (genvar g = 0; g < sss_pkg::NeedleMax; g++) begin : g_cell
    sss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv & ~len_zero),
      .clr_i    (accept & in_i.first_byte),
      .en_i     (cell_en[g]),
      .prev_i   (prev[g]),
      .data_i   (in_i.data_byte),
      .needle_i (needle_q[g*sss_pkg::ByteBits +: sss_pkg::ByteBits]),
      .bit_d_o  (pm_d[g]),
      .bit_q_o  (pm_q[g])
    );
  end

  assign hit = ~len_zero & pm_d[len_m1[sss_pkg::CellIdxW-1:0]];

  always_comb begin
    start_pos       = pos_cur - sss_pkg::IndexBits'(len_m1);
    res_valid       = adv & (len_zero | hit | in_i.last_byte);
    res.found       = len_zero | hit;
    res.match_index = '0;
    if (len_zero) begin
      res.match_index = sss_pkg::MatchIdxW'(pos_cur);
    end else if (hit) begin
      res.match_index = sss_pkg::MatchIdxW'(start_pos);
    end
    pos_d  = adv ? pos_cur + sss_pkg::IndexBits'(1) : pos_cur;
    done_d = done_cur | res_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      done_q <= done_d;
    end
  end

  sss_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_o       (out_o)
  );

  assign in_i.ready = ~full;

endmodule

>>> hw/rtl/sss_cell.sv
module sss_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         clr_i,
  input  logic                         en_i,
  input  logic                         prev_i,
  input  logic [sss_pkg::ByteBits-1:0] data_i,
  input  logic [sss_pkg::ByteBits-1:0] needle_i,
  output logic                         bit_d_o,
  output logic                         bit_q_o
);

  logic bit_d, bit_q;

  always_comb begin
    bit_d = prev_i & en_i & (data_i == needle_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (adv_i) begin
      bit_q <= bit_d;
    end else if (clr_i) begin
      bit_q <= 1'b0;
    end
  end

  assign bit_d_o = bit_d;
  assign bit_q_o = bit_q;

endmodule

>>> hw/rtl/sss_out_buf.sv
module sss_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sss_pkg::result_t push_data_i,
  output logic             full_o,
  sss_out_if.source        out_o
);

  logic             out_valid_q, skid_valid_q;
  sss_pkg::result_t out_data_q, skid_data_q;
  logic             pop;

  assign pop = out_valid_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        // skid full means no push this cycle; drain into the output stage
        if (pop) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_data_q <= skid_data_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_data_q <= push_data_i;
      end else begin
        out_data_q <= push_data_i;
      end
    end
  end

  assign full_o            = skid_valid_q;
  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_data_q.found;
  assign out_o.match_index = out_data_q.match_index;

endmodule
